[design/segx_pkg.sv]
package segx_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int LABEL_WIDTH     = 16;

  typedef struct packed {
    logic crosses;
    logic parallel;
    logic neg_x;
    logic neg_y;
  } segx_flags_t;

endpackage

[design/segx_geom.sv]
module segx_geom #(
  parameter int W = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [W-1:0]      ax,
  input  logic signed [W-1:0]      ay,
  input  logic signed [W-1:0]      cx,
  input  logic signed [W-1:0]      cy,
  input  logic signed [W-1:0]      ex,
  input  logic signed [W-1:0]      ey,
  input  logic signed [W-1:0]      gx,
  input  logic signed [W-1:0]      gy,
  output logic [2*W+2:0]           mag_num,
  output logic [2*W+2:0]           mag_den,
  output logic [W:0]               mag_dx,
  output logic [W:0]               mag_dy,
  output logic signed [W-1:0]      base_x,
  output logic signed [W-1:0]      base_y,
  output segx_pkg::segx_flags_t    flags
);
  import segx_pkg::*;

  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int NW = 2 * W + 3;

  // stage 1: differences (a,b)=ax,ay (c,d)=cx,cy (e,f)=ex,ey (g,h)=gx,gy
  logic signed [DW-1:0] d_ac, d_df, d_ce, d_bd, d_dh, d_cg, d_eg, d_hb, d_ga;
  logic signed [DW-1:0] d_fh, d_hd, d_gc, d_ge, d_fb, d_hf, d_ea, d_db, d_ca;
  logic signed [W-1:0]  bx1, by1;

  always_ff @(posedge clk) begin
    if (en) begin
      d_ac <= DW'(ax) - DW'(cx);  d_df <= DW'(cy) - DW'(ey);
      d_ce <= DW'(cx) - DW'(ex);  d_bd <= DW'(ay) - DW'(cy);
      d_dh <= DW'(cy) - DW'(gy);  d_cg <= DW'(cx) - DW'(gx);
      d_eg <= DW'(ex) - DW'(gx);  d_hb <= DW'(gy) - DW'(ay);
      d_ga <= DW'(gx) - DW'(ax);  d_fh <= DW'(ey) - DW'(gy);
      d_hd <= DW'(gy) - DW'(cy);  d_gc <= DW'(gx) - DW'(cx);
      d_ge <= DW'(gx) - DW'(ex);  d_fb <= DW'(ey) - DW'(ay);
      d_hf <= DW'(gy) - DW'(ey);  d_ea <= DW'(ex) - DW'(ax);
      d_db <= DW'(cy) - DW'(ay);  d_ca <= DW'(cx) - DW'(ax);
      bx1  <= ax;                 by1  <= ay;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] p1a, p1b, p2a, p2b, p3a, p3b, p4a, p4b, pna, pnb, pda, pdb;
  logic signed [DW-1:0] dx2, dy2;
  logic signed [W-1:0]  bx2, by2;

  always_ff @(posedge clk) begin
    if (en) begin
      p1a <= PW'(d_ac) * PW'(d_df);  p1b <= PW'(d_ce) * PW'(d_bd);
      p2a <= PW'(d_ac) * PW'(d_dh);  p2b <= PW'(d_cg) * PW'(d_bd);
      p3a <= PW'(d_eg) * PW'(d_hb);  p3b <= PW'(d_ga) * PW'(d_fh);
      p4a <= PW'(d_eg) * PW'(d_hd);  p4b <= PW'(d_gc) * PW'(d_fh);
      pna <= PW'(d_ge) * PW'(d_fb);  pnb <= PW'(d_hf) * PW'(d_ea);
      pda <= PW'(d_ge) * PW'(d_db);  pdb <= PW'(d_ca) * PW'(d_hf);
      dx2 <= d_ca;                   dy2 <= d_db;
      bx2 <= bx1;                    by2 <= by1;
    end
  end

  // stage 3: determinants
  logic signed [NW-1:0] o1, o2, o3, o4, num, den;
  logic signed [DW-1:0] dx3, dy3;
  logic signed [W-1:0]  bx3, by3;

  always_ff @(posedge clk) begin
    if (en) begin
      o1  <= NW'(p1a) - NW'(p1b);  o2  <= NW'(p2a) - NW'(p2b);
      o3  <= NW'(p3a) - NW'(p3b);  o4  <= NW'(p4a) - NW'(p4b);
      num <= NW'(pna) - NW'(pnb);  den <= NW'(pda) - NW'(pdb);
      dx3 <= dx2;                  dy3 <= dy2;
      bx3 <= bx2;                  by3 <= by2;
    end
  end

  // stage 4: signs, magnitudes, crossing decision
  logic [1:0] s1, s2, s3, s4;
  logic       num_nz, num_ng, den_ng;

  always_comb begin
    s1     = {o1 == '0, o1[NW-1]};
    s2     = {o2 == '0, o2[NW-1]};
    s3     = {o3 == '0, o3[NW-1]};
    s4     = {o4 == '0, o4[NW-1]};
    num_nz = num != '0;
    num_ng = num[NW-1];
    den_ng = den[NW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_num        <= num_ng ? NW'(-num) : NW'(num);
      mag_den        <= den_ng ? NW'(-den) : NW'(den);
      mag_dx         <= dx3[DW-1] ? DW'(-dx3) : DW'(dx3);
      mag_dy         <= dy3[DW-1] ? DW'(-dy3) : DW'(dy3);
      base_x         <= bx3;
      base_y         <= by3;
      flags.crosses  <= (s1 != s2) && (s3 != s4);
      flags.parallel <= den == '0;
      flags.neg_x    <= (dx3[DW-1] ^ num_ng ^ den_ng) & num_nz & (dx3 != '0);
      flags.neg_y    <= (dy3[DW-1] ^ num_ng ^ den_ng) & num_nz & (dy3 != '0);
    end
  end

endmodule

[design/segx_coord.sv]
module segx_coord #(
  parameter int W = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2*W+2:0]       mag_num,
  input  logic [2*W+2:0]       mag_den,
  input  logic [W:0]           mag_diff,
  input  logic                 neg,
  input  logic                 zero,
  input  logic signed [W-1:0]  base,
  output logic signed [W-1:0]  res
);
  import segx_pkg::*;

  localparam int DW  = W + 1;
  localparam int NW  = 2 * W + 3;
  localparam int HL  = NW / 2;
  localparam int HH  = NW - HL;
  localparam int LPW = HL + DW;
  localparam int HPW = HH + DW;
  localparam int PRW = NW + DW;
  localparam int XW  = PRW + 2;
  localparam int QW  = W + 2;
  localparam int SW  = W + 4;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  // C1: partial products
  logic [LPW-1:0]      p_lo;
  logic [HPW-1:0]      p_hi;
  logic [NW-1:0]       den1, den2;
  logic                neg1, neg2, neg3, zero1, zero2, zero3;
  logic signed [W-1:0] base1, base2, base3;

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo  <= LPW'(mag_num[HL-1:0]) * LPW'(mag_diff);
      p_hi  <= HPW'(mag_num[NW-1:HL]) * HPW'(mag_diff);
      den1  <= mag_den;
      neg1  <= neg;
      zero1 <= zero;
      base1 <= base;
    end
  end

  // C2: full product
  logic [PRW-1:0] prod;

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= PRW'(p_lo) + (PRW'(p_hi) << HL);
      den2  <= den1;
      neg2  <= neg1;
      zero2 <= zero1;
      base2 <= base1;
    end
  end

  // C3: rounded dividend 2*prod + den, divisor 2*den
  logic [XW-1:0] n_val;
  logic [NW:0]   d2_3;

  always_ff @(posedge clk) begin
    if (en) begin
      n_val <= {1'b0, prod, 1'b0} + XW'(den2);
      d2_3  <= {den2, 1'b0};
      neg3  <= neg2;
      zero3 <= zero2;
      base3 <= base2;
    end
  end

  // C4 and divide stages: restoring, one quotient bit per stage
  logic [NW:0]         rem_s  [0:QW];
  logic [NW:0]         d2_s   [0:QW];
  logic [QW-1:0]       nlow_s [0:QW];
  logic [QW-1:0]       q_s    [0:QW];
  logic                neg_s  [0:QW];
  logic                zero_s [0:QW];
  logic                ovf_s  [0:QW];
  logic signed [W-1:0] base_s [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= n_val[XW-1:QW];
      nlow_s[0] <= n_val[QW-1:0];
      ovf_s[0]  <= n_val[XW-1:QW] >= d2_3;
      d2_s[0]   <= d2_3;
      q_s[0]    <= '0;
      neg_s[0]  <= neg3;
      zero_s[0] <= zero3;
      base_s[0] <= base3;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [NW+1:0] trial, diff;

    always_comb begin
      trial = {rem_s[k], nlow_s[k][QW-1]};
      diff  = trial - {1'b0, d2_s[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1]  <= diff[NW+1] ? trial[NW:0] : diff[NW:0];
        q_s[k+1]    <= {q_s[k][QW-2:0], ~diff[NW+1]};
        nlow_s[k+1] <= {nlow_s[k][QW-2:0], 1'b0};
        d2_s[k+1]   <= d2_s[k];
        neg_s[k+1]  <= neg_s[k];
        zero_s[k+1] <= zero_s[k];
        ovf_s[k+1]  <= ovf_s[k];
        base_s[k+1] <= base_s[k];
      end
    end
  end

  // final: apply sign, add base, saturate; zero input forces zero
  logic signed [SW-1:0] bext, qext, sum;
  logic signed [W-1:0]  res_next;

  always_comb begin
    bext = SW'(base_s[QW]);
    qext = $signed({{(SW-QW){1'b0}}, q_s[QW]});
    sum  = neg_s[QW] ? bext - qext : bext + qext;
    if (zero_s[QW]) begin
      res_next = '0;
    end else if (ovf_s[QW]) begin
      res_next = neg_s[QW] ? CMIN : CMAX;
    end else if (sum > SW'(CMAX)) begin
      res_next = CMAX;
    end else if (sum < SW'(CMIN)) begin
      res_next = CMIN;
    end else begin
      res_next = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

[design/segment_intersection_point_core.sv]
// Segment pair intersection core.
// Slave channel (s_axis_*) takes one item per segment pair: the endpoints of
// segments A and B as signed fixed point (8 fraction bits) plus two labels.
// Master channel (m_axis_*) returns one item per pair: crosses flag, parallel
// flag, the intersection point of the supporting lines (rounded to nearest,
// saturated to the coordinate range, zero when parallel) and both labels.
// The pipeline has four stages of differences, products, determinants and
// signs, four stages of scaling multiply and dividend setup, then a
// restoring divider that produces one quotient bit per stage
// (COORD_WIDTH + 2 stages), and a final round/clamp.
// Throughput is one item per cycle while the receiver takes results.
// When m_axis_tready is low with a result waiting, the whole pipeline holds
// and s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears only the valid bits; data registers are not reset.
module segment_intersection_point_core #(
  parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y,
  // b_end_x, b_end_y, label_a, label_b, zero pad
  input  logic [((8*COORD_WIDTH+2*segx_pkg::LABEL_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // crosses, parallel, cross_x, cross_y, out_label_a, out_label_b, zero pad
  output logic [((2+2*COORD_WIDTH+2*segx_pkg::LABEL_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  import segx_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int NW     = 2 * W + 3;
  localparam int LAT    = W + 11;
  localparam int FD     = LAT - 4;
  localparam int LBW    = 2 * LABEL_WIDTH;
  localparam int OUT_TW = ((2 + 2 * W + LBW + 7) / 8) * 8;

  logic en;
  logic vld [0:LAT-1];

  assign en            = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  logic [NW-1:0]       mag_num, mag_den;
  logic [W:0]          mag_dx, mag_dy;
  logic signed [W-1:0] base_x, base_y, res_x, res_y;
  segx_flags_t         flags;

  segx_geom #(.W(W)) u_geom (
    .clk     (clk),
    .en      (en),
    .ax      ($signed(s_axis_tdata[W-1:0])),
    .ay      ($signed(s_axis_tdata[2*W-1:W])),
    .cx      ($signed(s_axis_tdata[3*W-1:2*W])),
    .cy      ($signed(s_axis_tdata[4*W-1:3*W])),
    .ex      ($signed(s_axis_tdata[5*W-1:4*W])),
    .ey      ($signed(s_axis_tdata[6*W-1:5*W])),
    .gx      ($signed(s_axis_tdata[7*W-1:6*W])),
    .gy      ($signed(s_axis_tdata[8*W-1:7*W])),
    .mag_num (mag_num),
    .mag_den (mag_den),
    .mag_dx  (mag_dx),
    .mag_dy  (mag_dy),
    .base_x  (base_x),
    .base_y  (base_y),
    .flags   (flags)
  );

  segx_coord #(.W(W)) u_coord_x (
    .clk      (clk),
    .en       (en),
    .mag_num  (mag_num),
    .mag_den  (mag_den),
    .mag_diff (mag_dx),
    .neg      (flags.neg_x),
    .zero     (flags.parallel),
    .base     (base_x),
    .res      (res_x)
  );

  segx_coord #(.W(W)) u_coord_y (
    .clk      (clk),
    .en       (en),
    .mag_num  (mag_num),
    .mag_den  (mag_den),
    .mag_diff (mag_dy),
    .neg      (flags.neg_y),
    .zero     (flags.parallel),
    .base     (base_y),
    .res      (res_y)
  );

  logic [LBW-1:0] lbl [0:LAT-1];
  logic [1:0]     fl  [0:FD-1];

  always_ff @(posedge clk) begin
    if (en) begin
      lbl[0] <= s_axis_tdata[8*W+LBW-1:8*W];
      for (int i = 1; i < LAT; i++) lbl[i] <= lbl[i-1];
      fl[0] <= {flags.parallel, flags.crosses};
      for (int i = 1; i < FD; i++) fl[i] <= fl[i-1];
    end
  end

  assign m_axis_tdata = OUT_TW'({lbl[LAT-1], res_y, res_x, fl[FD-1]});

endmodule
